// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the LED matrix driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is suspended while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/lmsb_pkg.sv =====
package lmsb_pkg;

  localparam int COLUMNS  = 4;
  localparam int MAX_ROWS = 4;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_TOGGLE = 2'd2;
  localparam logic [1:0] CMD_BLINK  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_SCAN_PERIOD = 2'd1;
  localparam logic [1:0] CFG_SCAN_ENABLE = 2'd2;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
  } mod_req_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [PERIOD_W-1:0] remainder;
  } mod_rsp_t;

endpackage

// ===== rtl/core/lmsb_if.sv =====
interface lmsb_in_if;
  import lmsb_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [TIME_W-1:0]   time_ms;
  logic [3:0]          led_index;
  logic [PERIOD_W-1:0] write_value;

  modport source (output valid, command, time_ms, led_index, write_value, input ready);
  modport sink   (input valid, command, time_ms, led_index, write_value, output ready);
endinterface

interface lmsb_out_if;
  logic       valid;
  logic       ready;
  logic       scan_done;
  logic [1:0] row_released;
  logic [1:0] row_active;
  logic [3:0] column_drive;

  modport source (output valid, scan_done, row_released, row_active, column_drive,
                  input ready);
  modport sink   (input valid, scan_done, row_released, row_active, column_drive,
                  output ready);
endinterface

// ===== rtl/core/lmsb_mod_unit.sv =====
module lmsb_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  lmsb_pkg::mod_req_t req,
  output lmsb_pkg::mod_rsp_t rsp
);
  import lmsb_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TIME_W-1:0]   dividend_r;
  logic [PERIOD_W-1:0] divisor_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W-1:0] rem_nxt;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial = {rem_r, dividend_r[TIME_W-1]};
    if (trial >= {1'b0, divisor_r}) begin
      rem_nxt = PERIOD_W'(trial - {1'b0, divisor_r});
    end else begin
      rem_nxt = trial[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(TIME_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TIME_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend_r <= req.dividend;
      divisor_r  <= req.divisor;
      rem_r      <= '0;
    end else if (busy_r) begin
      dividend_r <= {dividend_r[TIME_W-2:0], 1'b0};
      rem_r      <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/core/led_matrix_scan_with_blink.sv =====
// Multiplexed LED matrix driver for up to four rows of four columns, with a
// blink period per LED. Each request carries a command: set an LED, toggle an
// LED, give an LED a blink period, or a tick with the millisecond time. Every
// request yields exactly one result; only a tick that scans fills it, and then
// it names the row released, the row now pulled low and the four column
// drives for that row. A command request or a tick that does not scan goes
// from acceptance through the output state into the output register. A
// scanning tick steps through the columns; an LED that is off or steady
// needs no division, while a blinking column waits for the time modulo the
// blink period from a single shared remainder unit that retires one dividend
// bit per cycle. The block accepts no new request while a tick is scanning
// its columns; a finished result waits in the output register and the next
// request may be accepted meanwhile. Configuration writes are taken at any
// edge with cfg_we high and must only be made while the block is idle.
`include "assert_macros.svh"

module led_matrix_scan_with_blink #(
  parameter int LED_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  lmsb_in_if.sink    in_req,
  lmsb_out_if.source out_res
);
  import lmsb_pkg::*;

  localparam int IDX_W = $clog2(LED_COUNT);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COL  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // Configuration registers.
  logic [2:0] rows_in_use_r;
  logic [7:0] scan_period_r;
  logic       scan_enable_r;

  // LED store and scan state.
  logic [LED_COUNT-1:0] led_on_r;
  logic [PERIOD_W-1:0]  blink_r [LED_COUNT];
  logic [1:0]           row_r;
  logic [TIME_W-1:0]    last_scan_r;

  // Working registers of the sequencer.
  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [1:0]        col_r;
  logic [1:0]        released_r;
  logic [3:0]        drive_r;
  logic              scan_r;
  logic [TIME_W-1:0] time_r;

  // Output register.
  logic       out_valid_r;
  logic       out_done_r;
  logic [1:0] out_released_r;
  logic [1:0] out_active_r;
  logic [3:0] out_drive_r;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic                accept;
  logic                idx_ok;
  logic [IDX_W-1:0]    idx;
  logic [TIME_W-1:0]   elapsed;
  logic                scan_now;
  logic [2:0]          rows_eff;
  logic [1:0]          row_inc;
  logic [1:0]          row_next;
  logic [3:0]          num;
  logic                num_ok;
  logic [PERIOD_W-1:0] col_period;
  logic                col_on;
  logic                col_blinks;
  logic                col_lit;
  logic                col_last;
  logic                out_free;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;

  // Rows in use of zero behaves as one; anything above four is held at four.
  always_comb begin
    if (rows_in_use_r == 3'd0) begin
      rows_eff = 3'd1;
    end else if (rows_in_use_r > 3'(MAX_ROWS)) begin
      rows_eff = 3'(MAX_ROWS);
    end else begin
      rows_eff = rows_in_use_r;
    end
  end

  // The elapsed time wraps modulo 2^32 like the time stamp itself.
  assign elapsed  = in_req.time_ms - last_scan_r;
  assign scan_now = scan_enable_r && (elapsed > TIME_W'(scan_period_r));

  // The row wraps to zero once it would leave the rows in use; this also
  // catches a row left beyond range after rows_in_use was lowered.
  assign row_inc  = row_r + 2'd1;
  assign row_next = ({1'b0, row_inc} >= rows_eff) ? 2'd0 : row_inc;

  // Commands aimed past the last LED are dropped.
  assign idx_ok = {1'b0, in_req.led_index} < 5'(LED_COUNT);
  assign idx    = in_req.led_index[IDX_W-1:0];

  // LED number of the column under test; numbers past the last LED read dark.
  assign num        = {row_r, col_r};
  assign num_ok     = {1'b0, num} < 5'(LED_COUNT);
  assign col_period = num_ok ? blink_r[num[IDX_W-1:0]] : '0;
  assign col_on     = num_ok && led_on_r[num[IDX_W-1:0]];
  assign col_blinks = col_period != '0;
  assign col_last   = col_r == 2'(COLUMNS - 1);

  // A blinking LED is lit in the upper half of its period.
  always_comb begin
    if (state_r == S_WAIT) begin
      col_lit = mod_rsp.remainder > (col_period >> 1);
    end else begin
      col_lit = col_on && !col_blinks;
    end
  end

  assign mod_req.start    = (state_r == S_COL) && col_on && col_blinks;
  assign mod_req.dividend = time_r;
  assign mod_req.divisor  = col_period;

  lmsb_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.command == CMD_TICK && scan_now) begin
            state_nxt = S_COL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_COL: begin
        if (mod_req.start) begin
          state_nxt = S_WAIT;
        end else if (col_last) begin
          state_nxt = S_OUT;
        end
      end
      S_WAIT: begin
        if (mod_rsp.done) begin
          state_nxt = col_last ? S_OUT : S_COL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_req.ready = state_r == S_IDLE;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= 3'd1;
      scan_period_r <= 8'd2;
      scan_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata[2:0];
        CFG_SCAN_PERIOD: scan_period_r <= cfg_wdata;
        CFG_SCAN_ENABLE: scan_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // LED store, updated by the command requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_on_r <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        blink_r[i] <= '0;
      end
    end else if (accept && idx_ok) begin
      case (in_req.command)
        CMD_SET:    led_on_r[idx] <= in_req.write_value[0];
        CMD_TOGGLE: led_on_r[idx] <= !led_on_r[idx];
        CMD_BLINK:  blink_r[idx]  <= in_req.write_value;
        default: ;
      endcase
    end
  end

  // Scan sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= 2'd0;
      last_scan_r <= '0;
      scan_r      <= 1'b0;
      col_r       <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && accept) begin
        scan_r <= (in_req.command == CMD_TICK) && scan_now;
        if (in_req.command == CMD_TICK && scan_now) begin
          last_scan_r <= in_req.time_ms;
          row_r       <= row_next;
          col_r       <= 2'd0;
        end
      end else if ((state_r == S_COL && !mod_req.start) ||
                   (state_r == S_WAIT && mod_rsp.done)) begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  // Payload of the scan in progress.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      time_r     <= in_req.time_ms;
      released_r <= row_r;
      drive_r    <= '0;
    end else if ((state_r == S_COL && !mod_req.start) ||
                 (state_r == S_WAIT && mod_rsp.done)) begin
      drive_r[col_r] <= col_lit;
    end
  end

  // Output register: a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A result without a scan carries all zeros.
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_done_r     <= scan_r;
      out_released_r <= scan_r ? released_r : 2'd0;
      out_active_r   <= scan_r ? row_r : 2'd0;
      out_drive_r    <= scan_r ? drive_r : 4'd0;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.scan_done    = out_done_r;
  assign out_res.row_released = out_released_r;
  assign out_res.row_active   = out_active_r;
  assign out_res.column_drive = out_drive_r;

  // Column work only happens for a tick that is scanning.
  `ASSERT_CLK(a_col_needs_scan, clk, rst_n, (state_r == S_COL || state_r == S_WAIT) |-> scan_r, "column work outside a scan")
  // The remainder unit runs only while the sequencer waits for it.
  `ASSERT_CLK(a_mod_owner, clk, rst_n, mod_rsp.busy |-> (state_r == S_WAIT), "remainder unit busy outside the wait state")
  // A result without a scan drives nothing.
  `ASSERT_CLK(a_no_scan_dark, clk, rst_n, (out_valid_r && !out_done_r) |-> (out_drive_r == 4'd0 && out_active_r == 2'd0 && out_released_r == 2'd0), "unscanned result not dark")
  // After reset the block is idle with no result pending.
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "block not idle after reset")

endmodule

// ===== test/led_matrix_scan_with_blink_tb.sv =====
`timescale 1ns / 1ps

module led_matrix_scan_with_blink_tb;
  import lmsb_pkg::*;

  // The block is built with its default LED count, so all sixteen LEDs exist.
  localparam int LED_TOTAL = 16;

  // Cycles without any accepted request or result before the run is abandoned.
  // The limit leaves a wide margin over the slowest result (a row of four
  // blinking LEDs), even under heavy stalling.
  localparam int WATCHDOG_LIMIT = 4000;

  // Cycles allowed at the very end for a stray result to show up.
  localparam int END_SETTLE = 150;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0]          command;
    logic [TIME_W-1:0]   time_ms;
    logic [3:0]          led_index;
    logic [PERIOD_W-1:0] write_value;
  } matrix_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic       scan_done;
    logic [1:0] row_released;
    logic [1:0] row_active;
    logic [3:0] column_drive;
  } scan_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  lmsb_in_if  req_ch ();
  lmsb_out_if res_ch ();

  led_matrix_scan_with_blink DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_res   (res_ch)
  );

  // Free-running 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Our own copy of the matrix: what each LED is set to, its blink period,
  // the row being driven and when the last scan happened.
  logic                lamp_on       [LED_TOTAL];
  logic [PERIOD_W-1:0] lamp_blink_ms [LED_TOTAL];
  logic [1:0]          scan_row;
  logic [TIME_W-1:0]   last_scan_ms;

  // Our copy of the configuration registers, updated as they are written.
  logic [2:0] rows_reg;
  logic [7:0] period_reg;
  logic       enable_reg;

  // Results still owed by the block, oldest first.
  scan_result_t pending_scans[$];

  int unsigned mismatches;
  int          idle_cycles;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int sender_idle_pct;
  int receiver_stall_pct;

  // Running millisecond clock used to build tick requests.
  logic [TIME_W-1:0] tick_clock_ms;

  // Applies one accepted request to our copy of the matrix and returns the
  // result the block must produce for it.
  function automatic scan_result_t apply_request(matrix_req_t r);
    scan_result_t      res;
    logic [TIME_W-1:0] elapsed;
    int                rows_eff;
    int                next_row;
    int                lamp;
    res = '0;
    if (r.command == CMD_TICK) begin
      elapsed = r.time_ms - last_scan_ms;
      if (enable_reg && elapsed > period_reg) begin
        // A rows setting of zero behaves as one, anything above four as four.
        if (rows_reg == 0) begin
          rows_eff = 1;
        end else if (rows_reg > MAX_ROWS) begin
          rows_eff = MAX_ROWS;
        end else begin
          rows_eff = rows_reg;
        end
        last_scan_ms     = r.time_ms;
        res.scan_done    = 1'b1;
        res.row_released = scan_row;
        // The row also falls back to zero when it has run past a rows
        // setting that was lowered since the last scan.
        next_row = scan_row + 1;
        if (next_row >= rows_eff) begin
          next_row = 0;
        end
        scan_row       = next_row[1:0];
        res.row_active = scan_row;
        for (int c = 0; c < COLUMNS; c++) begin
          lamp = next_row * COLUMNS + c;
          // A blinking LED is lit in the upper half of its period only.
          if (lamp < LED_TOTAL && lamp_on[lamp] &&
              (lamp_blink_ms[lamp] == 0 ||
               (r.time_ms % lamp_blink_ms[lamp]) > (lamp_blink_ms[lamp] / 2))) begin
            res.column_drive[c] = 1'b1;
          end
        end
      end
    end else if (r.led_index < LED_TOTAL) begin
      case (r.command)
        CMD_SET: begin
          lamp_on[r.led_index] = r.write_value[0];
        end
        CMD_TOGGLE: begin
          lamp_on[r.led_index] = !lamp_on[r.led_index];
        end
        default: begin
          lamp_blink_ms[r.led_index] = r.write_value;
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    mismatches++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  // Result checking and request prediction share one process. A result can
  // never belong to a request accepted on the same edge, so checking first
  // and predicting second keeps the queue order exact.
  always @(posedge clk) begin : result_check
    scan_result_t got;
    scan_result_t want;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.scan_done, res_ch.row_released, res_ch.row_active,
                res_ch.column_drive};
        if (pending_scans.size() == 0) begin
          report_mismatch("result with no request pending", got, 0);
        end else begin
          want = pending_scans.pop_front();
          if (got.scan_done !== want.scan_done) begin
            report_mismatch("scan_done", got.scan_done, want.scan_done);
          end
          if (got.row_released !== want.row_released) begin
            report_mismatch("row_released", got.row_released, want.row_released);
          end
          if (got.row_active !== want.row_active) begin
            report_mismatch("row_active", got.row_active, want.row_active);
          end
          if (got.column_drive !== want.column_drive) begin
            report_mismatch("column_drive", got.column_drive, want.column_drive);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_scans.push_back(apply_request('{req_ch.command, req_ch.time_ms,
                                                req_ch.led_index, req_ch.write_value}));
      end
    end
  end

  // The receiver stalls at random, at the rate set for the current phase.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: gives up when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("led_matrix_scan_with_blink test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one request and returns at the edge where it was accepted. The
  // valid line stays high afterwards; the next call either replaces the
  // request or drops valid for an idle gap.
  task automatic send_request(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
                              input logic [3:0] idx, input logic [PERIOD_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.time_ms     <= t;
    req_ch.led_index   <= idx;
    req_ch.write_value <= val;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has come back. The first
  // edge lets the prediction for the last accepted request land in the queue.
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_scans.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called when idle.
  task automatic program_scan(input logic [2:0] rows, input logic [7:0] period,
                              input logic enable);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_wdata <= {5'd0, rows};
    @(posedge clk);
    rows_reg  = rows;
    cfg_index <= CFG_SCAN_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    period_reg = period;
    cfg_index <= CFG_SCAN_ENABLE;
    cfg_wdata <= {7'd0, enable};
    @(posedge clk);
    enable_reg = enable;
    cfg_we    <= 1'b0;
  endtask

  // LED commands with scanning still disabled from reset. A tick must not
  // scan, set LED must look at bit 0 only, and toggles must flip state.
  task automatic test_led_commands();
    send_request(CMD_TICK,   32'd100, 4'd0,  16'hFFFF);
    send_request(CMD_SET,    32'd0,   4'd0,  16'hFFFE);
    send_request(CMD_SET,    32'd0,   4'd1,  16'h0001);
    send_request(CMD_TOGGLE, 32'd0,   4'd2,  16'h0000);
    send_request(CMD_TOGGLE, 32'd0,   4'd2,  16'h0000);
    send_request(CMD_TOGGLE, 32'd0,   4'd2,  16'h0000);
    send_request(CMD_SET,    32'd0,   4'd5,  16'hFFFF);
    send_request(CMD_SET,    32'd0,   4'd15, 16'h0001);
    send_request(CMD_BLINK,  32'd0,   4'd1,  16'hFFFF);
    send_request(CMD_BLINK,  32'd0,   4'd15, 16'h0001);
    send_request(CMD_BLINK,  32'd0,   4'd5,  16'h0003);
  endtask

  // Row stepping: four rows, then the row running past a lowered rows
  // setting, then a setting above four and a setting of zero.
  task automatic test_row_sequence();
    wait_results_drained();
    program_scan(3'd4, 8'd0, 1'b1);
    // No time has passed since reset, so the first tick must not scan.
    send_request(CMD_TICK, 32'h0000_0000, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0001, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0002, 4'd0, 16'h0000);

    // The row now sits at two, which is past a setting of two rows.
    wait_results_drained();
    program_scan(3'd2, 8'd255, 1'b1);
    send_request(CMD_TICK, 32'hFFFF_FFFF, 4'd0, 16'h0000);

    wait_results_drained();
    program_scan(3'd7, 8'd0, 1'b1);
    send_request(CMD_TICK, 32'h0000_0100, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0101, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0102, 4'd0, 16'h0000);

    wait_results_drained();
    program_scan(3'd0, 8'd0, 1'b1);
    send_request(CMD_TICK, 32'h0000_0103, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0104, 4'd0, 16'h0000);
  endtask

  // Scan period at its maximum: an elapsed time equal to the period must not
  // scan, one more must, including across the wrap of the millisecond time.
  task automatic test_period_wrap();
    wait_results_drained();
    program_scan(3'd4, 8'd255, 1'b1);
    send_request(CMD_TICK, 32'h0000_0203, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0204, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'hFFFF_FF80, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_007F, 4'd0, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0080, 4'd0, 16'h0000);
    tick_clock_ms = 32'h0000_0080;
  endtask

  // Random traffic in twelve phases. Each phase gets its own configuration
  // and its own idling pattern, cycling through no idling, a mostly idle
  // sender, a mostly stalled receiver and light idling on both sides.
  task automatic test_random_traffic();
    logic [2:0]          rows;
    logic [7:0]          period;
    logic                enable;
    logic [1:0]          cmd;
    logic [PERIOD_W-1:0] val;
    int                  pick;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 83;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 83;
        end
        default: begin
          sender_idle_pct    = 11;
          receiver_stall_pct = 11;
        end
      endcase

      // Mostly short periods so that ticks scan often; a few phases pin the
      // extremes of each register.
      rows   = 3'($urandom_range(4, 1));
      period = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                          8'($urandom_range(8));
      enable = 1'b1;
      case (phase)
        0: begin
          rows   = 3'd4;
          period = 8'd0;
        end
        1: begin
          rows   = 3'd1;
          period = 8'd255;
        end
        5: enable = 1'b0;
        6: rows = 3'd0;
        7: rows = 3'd7;
        default: ;
      endcase
      wait_results_drained();
      program_scan(rows, period, enable);

      for (int n = 0; n < 88; n++) begin
        // Once, the sender holds off until the block has caught up.
        if (phase == 2 && n == 44) begin
          wait_results_drained();
        end
        if ($urandom_range(1) == 0) begin
          // Ticks mostly follow a steadily advancing clock; some jump anywhere.
          if ($urandom_range(9) == 0) begin
            tick_clock_ms = $urandom();
          end else begin
            tick_clock_ms = tick_clock_ms + $urandom_range(2 * period + 2);
          end
          send_request(CMD_TICK, tick_clock_ms, 4'($urandom_range(15)),
                       16'($urandom_range(16'hFFFF)));
        end else begin
          cmd = 2'($urandom_range(3, 1));
          if (cmd == CMD_BLINK) begin
            // Blink periods are mostly zero or short so that they show in scans.
            pick = $urandom_range(9);
            if (pick < 4) begin
              val = '0;
            end else if (pick < 8) begin
              val = 16'($urandom_range(40, 1));
            end else begin
              val = 16'($urandom_range(16'hFFFF));
            end
          end else begin
            val = 16'($urandom_range(16'hFFFF));
          end
          send_request(cmd, $urandom(), 4'($urandom_range(15)), val);
        end
      end
    end
  endtask

  initial begin
    // Every input gets a known value before the first clock edge.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_ROWS_IN_USE;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_TICK;
    req_ch.time_ms     = '0;
    req_ch.led_index   = '0;
    req_ch.write_value = '0;
    res_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatches         = 0;
    idle_cycles        = 0;
    tick_clock_ms      = '0;

    // Our copy of the block starts from its reset state.
    for (int i = 0; i < LED_TOTAL; i++) begin
      lamp_on[i]       = 1'b0;
      lamp_blink_ms[i] = '0;
    end
    scan_row     = '0;
    last_scan_ms = '0;
    rows_reg     = 3'd1;
    period_reg   = 8'd2;
    enable_reg   = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_led_commands();
    test_row_sequence();
    test_period_wrap();
    test_random_traffic();

    // Let every owed result arrive, then watch a while for anything extra.
    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);

    if (mismatches == 0 && pending_scans.size() == 0) begin
      $display("led_matrix_scan_with_blink test passed");
    end else begin
      $display("led_matrix_scan_with_blink test failed");
    end
    $finish;
  end

endmodule
